// ===== hdl/sorted_priority_queue_core_defines.svh =====
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SPQ_ASSERT(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("sorted priority queue check failed");
`define SPQ_ASSERT_ALWAYS(label, clock, prop) \
  label: assert property (@(posedge clock) prop) \
    else $error("sorted priority queue invariant failed");
`else
`define SPQ_ASSERT(label, clock, reset, prop)
`define SPQ_ASSERT_ALWAYS(label, clock, prop)
`endif

`endif

// ===== hdl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int PRIO_W = 16;
  localparam int OCC_W = 5;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } action_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   del;
    entry_t fresh;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/spq_cell.sv =====
// One cell of the sorted chain: holds an entry and shifts with its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
  input  wire logic          clk,
  input  wire spq_pkg::ctrl_t ctrl,
  input  wire logic          occupied,
  input  wire logic          left_after,
  input  wire spq_pkg::entry_t left_entry,
  input  wire spq_pkg::entry_t right_entry,
  output spq_pkg::entry_t    entry,
  output logic               after
);
  import spq_pkg::*;

  entry_t entry_next;

  // new entry belongs at or before this cell
  assign after = !occupied || (entry.prio > ctrl.fresh.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.ins) begin
      if (left_after) begin
        entry_next = left_entry;
      end else if (after) begin
        entry_next = ctrl.fresh;
      end
    end else if (ctrl.del) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ===== hdl/sorted_priority_queue_core.sv =====
// Sorted priority queue built from a chain of shifting cells.
// The result is registered in the cycle after the request is accepted.
// Throughput: one request per cycle while the output is drained; every cell updates in the same cycle.
// A request is taken whenever the output register is empty or being drained.
// Reset: synchronous, clears the entry count and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_priority_queue_core_defines.svh"

module sorted_priority_queue_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          action,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] in_value,
  input  wire logic signed [spq_pkg::PRIO_W-1:0]  in_priority,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [spq_pkg::VALUE_W-1:0] out_value,
  output logic [1:0]                         status,
  output logic [spq_pkg::OCC_W-1:0]          occupancy
);
  import spq_pkg::*;

  logic             accept;
  logic             is_insert;
  logic             full;
  logic             empty;
  logic             drop_ins;
  ctrl_t            ctrl;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W+OCC_W-1:0] occ_ext;
  entry_t           cells [DEPTH];
  logic             after [DEPTH];

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_insert = (action == ACT_INSERT);
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign drop_ins  = accept && is_insert && full;

  assign ctrl.ins        = accept && is_insert && !full;
  assign ctrl.del        = accept && !is_insert && !empty;
  assign ctrl.fresh.value = in_value;
  assign ctrl.fresh.prio  = in_priority;

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.del) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_next};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (CNT_W'(i) < count),
      .left_after  ((i == 0) ? 1'b0 : after[(i == 0) ? 0 : i - 1]),
      .left_entry  ((i == 0) ? ctrl.fresh : cells[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == DEPTH - 1) ? ctrl.fresh : cells[(i == DEPTH - 1) ? i : i + 1]),
      .entry       (cells[i]),
      .after       (after[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value <= ctrl.del ? cells[0].value : '0;
      occupancy <= occ_ext[OCC_W-1:0];
      if (is_insert) begin
        status <= full ? ST_OVERFLOW : ST_OK;
      end else begin
        status <= empty ? ST_UNDERFLOW : ST_OK;
      end
    end
  end

  `SPQ_ASSERT_ALWAYS(a_count_bound, clk, rst || (count <= CNT_W'(DEPTH)))
  `SPQ_ASSERT(a_overflow, clk, rst, drop_ins |=> (status == ST_OVERFLOW && $stable(count)))
  `SPQ_ASSERT(a_pop_value, clk, rst, ctrl.del |=> (out_value == $past(cells[0].value)))
  `SPQ_ASSERT(a_pop_count, clk, rst, ctrl.del |=> (count == $past(count) - CNT_W'(1)))
  `SPQ_ASSERT(a_front_sorted, clk, rst, (count >= CNT_W'(2)) |-> (cells[0].prio <= cells[1].prio))

endmodule

`default_nettype wire

// ===== tb/sorted_priority_queue_checker.sv =====
// Checker for the sorted priority queue: tracks requests, predicts responses, compares.
`timescale 1ns / 1ps

module sorted_priority_queue_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               action,
  input  logic signed [spq_pkg::VALUE_W-1:0] in_value,
  input  logic signed [spq_pkg::PRIO_W-1:0]  in_priority,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [spq_pkg::VALUE_W-1:0] out_value,
  input  logic [1:0]                         status,
  input  logic [spq_pkg::OCC_W-1:0]          occupancy,
  output int                                 failures,
  output int                                 awaited_count
);
  import spq_pkg::*;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    status_t                   st;
    logic [OCC_W-1:0]          occ;
  } queue_response_t;

  logic signed [VALUE_W-1:0] held_value [DEPTH];
  logic signed [PRIO_W-1:0]  held_prio  [DEPTH];
  int                        held_count;
  queue_response_t           awaited_responses [$];

  initial begin
    failures = 0;
    awaited_count = 0;
    held_count = 0;
  end

  function automatic queue_response_t serve_request(action_t act,
                                                    logic signed [VALUE_W-1:0] val,
                                                    logic signed [PRIO_W-1:0] prio);
    queue_response_t r;
    int pos;
    r.value = '0;
    r.st = ST_OK;
    if (act == ACT_INSERT) begin
      if (held_count >= DEPTH) begin
        r.st = ST_OVERFLOW;
      end else begin
        pos = 0;
        while (pos < held_count && held_prio[pos] <= prio) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_value[pos] = val;
        held_prio[pos] = prio;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.st = ST_UNDERFLOW;
      end else begin
        r.value = held_value[0];
        for (int i = 1; i < held_count; i++) begin
          held_value[i-1] = held_value[i];
          held_prio[i-1] = held_prio[i];
        end
        held_count--;
      end
    end
    r.occ = OCC_W'(held_count);
    return r;
  endfunction

  always @(posedge clk) begin
    queue_response_t want;
    if (rst) begin
      awaited_responses.delete();
      held_count = 0;
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        if (awaited_responses.size() == 0) begin
          failures++;
          $display("%0t: response with none expected: value %0d status %0d occupancy %0d",
                   $time, out_value, status, occupancy);
        end else begin
          want = awaited_responses.pop_front();
          if (out_value !== want.value) begin
            failures++;
            $display("%0t: out_value expected %0d got %0d", $time, want.value, out_value);
          end
          if (status !== want.st) begin
            failures++;
            $display("%0t: status expected %0d got %0d", $time, want.st, status);
          end
          if (occupancy !== want.occ) begin
            failures++;
            $display("%0t: occupancy expected %0d got %0d", $time, want.occ, occupancy);
          end
        end
      end
      if (in_valid && in_ready === 1'b1)
        awaited_responses.push_back(serve_request(action_t'(action), in_value, in_priority));
    end
    awaited_count <= awaited_responses.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top-level testbench for the sorted priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import spq_pkg::*;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic                      action;
  logic signed [VALUE_W-1:0] in_value;
  logic signed [PRIO_W-1:0]  in_priority;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [VALUE_W-1:0] out_value;
  logic [1:0]                status;
  logic [OCC_W-1:0]          occupancy;

  int failures;
  int awaited_count;
  bit send_calm;
  bit recv_calm;
  bit hold_req;
  int unsigned stall_left;

  sorted_priority_queue_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .in_value(in_value), .in_priority(in_priority),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .status(status), .occupancy(occupancy)
  );

  sorted_priority_queue_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .in_value(in_value), .in_priority(in_priority),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .status(status), .occupancy(occupancy),
    .failures(failures), .awaited_count(awaited_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // drain responses, with short stalls, rare long ones and a requested long hold
  initial begin
    int unsigned r;
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 79;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!recv_calm) begin
          r = $urandom_range(0, 99);
          if (r < 15)
            stall_left = $urandom_range(1, 3);
          else if (r < 17)
            stall_left = $urandom_range(10, 30);
        end
      end
    end
  end

  task automatic offer_request(action_t act, logic signed [VALUE_W-1:0] val,
                               logic signed [PRIO_W-1:0] prio);
    int unsigned r;
    int unsigned gap;
    gap = 0;
    if (!send_calm) begin
      r = $urandom_range(0, 99);
      if (r >= 92)
        gap = $urandom_range(5, 25);
      else if (r >= 70)
        gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    in_value <= val;
    in_priority <= prio;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [PRIO_W-1:0] pick_priority();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return PRIO_W'($urandom_range(0, 7));
    if (r < 75) return PRIO_W'(int'($urandom_range(0, 8)) - 4);
    if (r < 93) return PRIO_W'($urandom());
    return r[0] ? 16'sh7fff : 16'sh8000;
  endfunction

  initial begin
    int unsigned insert_pct;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_INSERT;
    in_value = '0;
    in_priority = '0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    offer_request(ACT_DELETE, 32'sh1234_5678, 16'sh0040);
    offer_request(ACT_INSERT, 32'sh7fff_ffff, 16'sh0000);
    offer_request(ACT_INSERT, 32'sh8000_0000, 16'sh7fff);
    offer_request(ACT_INSERT, 32'sh0000_0000, 16'sh8000);
    offer_request(ACT_INSERT, -32'sd1, 16'sh0000);
    offer_request(ACT_INSERT, 32'sh5555_5555, 16'sh0000);
    offer_request(ACT_INSERT, 32'shaaaa_aaaa, -16'sd1);
    offer_request(ACT_INSERT, 32'sh0000_0001, 16'sh7fff);
    offer_request(ACT_INSERT, 32'sh0000_0002, 16'sh8000);
    for (int k = 0; k < 8; k++)
      offer_request(ACT_INSERT, VALUE_W'(1000 + k), PRIO_W'(100 + (k % 3)));
    offer_request(ACT_INSERT, 32'sh0bad_0bad, 16'sh0001);
    repeat (6) offer_request(ACT_DELETE, $urandom(), PRIO_W'($urandom()));

    for (int ph = 0; ph < 12; ph++) begin
      insert_pct = (ph % 3 == 0) ? 80 : (ph % 3 == 1) ? 20 : 50;
      send_calm = (ph == 4);
      recv_calm = (ph == 4);
      if (ph == 7) begin
        send_calm = 1'b1;
        hold_req = 1'b1;
      end
      if (ph == 9) begin
        in_valid <= 1'b0;
        wait (awaited_count == 0);
        @(negedge clk);
      end
      for (int k = 0; k < 132; k++) begin
        if ($urandom_range(0, 99) < insert_pct)
          offer_request(ACT_INSERT, $urandom(), pick_priority());
        else
          offer_request(ACT_DELETE, $urandom(), PRIO_W'($urandom()));
      end
    end
    in_valid <= 1'b0;

    wait (awaited_count == 0);
    repeat (10) @(posedge clk);
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_core.sv
tb/sorted_priority_queue_checker.sv
tb/tb.sv
